// ----- src/sadr_pkg.sv -----
package sadr_pkg;

  localparam int ANGLE_TBL_SIZE = 24;
  localparam int ITER_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W = 128;
  localparam int OUT_DATA_W = 120;
  localparam int DEF_CORDIC_ITERATIONS = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_LIMIT = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_MXY, S_MYY, S_MZZ, S_MAF, S_VINIT, S_VITER,
    S_VDONE, S_RINIT, S_RITER, S_RDONE, S_MXS, S_MYC, S_UPDY, S_DONE
  } sadr_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DECIDE, OP_MXY, OP_MYY, OP_MZZ, OP_MAF, OP_VINIT,
    OP_VITER, OP_VDONE, OP_RINIT, OP_RITER, OP_RDONE, OP_MXS, OP_MYC,
    OP_UPDY_OUT_PREP, OP_OUT
  } sadr_op_t;

  typedef struct packed {
    sadr_op_t          op;
    logic [ITER_W-1:0] iter;
  } sadr_cmd_t;

  typedef struct packed {
    logic restart;
    logic skip;
    logic out_free;
  } sadr_sts_t;

  // Arctangent of 2^-i as a binary angle with 2^31 equal to pi.
  function automatic logic [29:0] atan_lut(input logic [ITER_W-1:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10680350;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -35'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- src/sadr_ctrl.sv -----
module sadr_ctrl
  import sadr_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  sadr_sts_t sts,
  output sadr_cmd_t cmd
);

  localparam int N_ITER = (CORDIC_ITERATIONS > ANGLE_TBL_SIZE) ? ANGLE_TBL_SIZE
                                                               : CORDIC_ITERATIONS;
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(N_ITER - 1);

  sadr_state_t       state_r, state_nxt;
  logic [ITER_W-1:0] ctr_r, ctr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ctr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ctr_r   <= ctr_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctr_nxt   = ctr_r;
    cmd.op    = OP_NONE;
    cmd.iter  = ctr_r;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.op    = OP_DECIDE;
        state_nxt = (sts.restart || sts.skip) ? S_DONE : S_MXY;
      end
      S_MXY: begin
        cmd.op    = OP_MXY;
        state_nxt = S_MYY;
      end
      S_MYY: begin
        cmd.op    = OP_MYY;
        state_nxt = S_MZZ;
      end
      S_MZZ: begin
        cmd.op    = OP_MZZ;
        state_nxt = S_MAF;
      end
      S_MAF: begin
        cmd.op    = OP_MAF;
        state_nxt = S_VINIT;
      end
      S_VINIT: begin
        cmd.op    = OP_VINIT;
        ctr_nxt   = '0;
        state_nxt = S_VITER;
      end
      S_VITER: begin
        cmd.op = OP_VITER;
        if (ctr_r == ITER_LAST) begin
          ctr_nxt   = '0;
          state_nxt = S_VDONE;
        end else begin
          ctr_nxt = ctr_r + 1'b1;
        end
      end
      S_VDONE: begin
        cmd.op    = OP_VDONE;
        state_nxt = S_RINIT;
      end
      S_RINIT: begin
        cmd.op    = OP_RINIT;
        ctr_nxt   = '0;
        state_nxt = S_RITER;
      end
      S_RITER: begin
        cmd.op = OP_RITER;
        if (ctr_r == ITER_LAST) begin
          ctr_nxt   = '0;
          state_nxt = S_RDONE;
        end else begin
          ctr_nxt = ctr_r + 1'b1;
        end
      end
      S_RDONE: begin
        cmd.op    = OP_RDONE;
        state_nxt = S_MXS;
      end
      S_MXS: begin
        cmd.op    = OP_MXS;
        state_nxt = S_MYC;
      end
      S_MYC: begin
        cmd.op    = OP_MYC;
        state_nxt = S_UPDY;
      end
      S_UPDY: begin
        cmd.op    = OP_UPDY_OUT_PREP;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- src/sadr_dp.sv -----
module sadr_dp
  import sadr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tuser,
  input  logic [IN_DATA_W-1:0]   in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,
  input  sadr_cmd_t              cmd,
  output sadr_sts_t              sts
);

  // Configuration registers.
  logic signed [31:0] start_x_r, start_y_r;
  logic signed [15:0] start_hd_r;
  logic [14:0]        lat_lim_r;
  logic [30:0]        fwd_lim_r;

  // Latched request.
  logic               mode_r;
  logic signed [15:0] enc_r, qw_r, qx_r, qy_r, qz_r, alat_r, afwd_r;
  logic [15:0]        dt_r;

  // Navigation state.
  logic signed [31:0] xpos_r, ypos_r, imu_r, chosen_r;
  logic signed [15:0] hd_r;
  logic               lat_r, fwd_r, upd_r;

  // Working registers.
  logic signed [65:0] prod_r;
  logic signed [33:0] sa_r, ca_r;
  logic signed [35:0] cx_r, cy_r;
  logic signed [33:0] cz_r;
  logic               degen_r, flip_r;
  logic signed [31:0] sin_r, cos_r, dist_r;

  logic               ovalid_r;
  logic [OUT_DATA_W-1:0] odata_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic               mul_en;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      OP_DECIDE: begin mul_a = 33'(qw_r); mul_b = 33'(qz_r); end
      OP_MXY:    begin mul_a = 33'(qx_r); mul_b = 33'(qy_r); end
      OP_MYY:    begin mul_a = 33'(qy_r); mul_b = 33'(qy_r); end
      OP_MZZ:    begin mul_a = 33'(qz_r); mul_b = 33'(qz_r); end
      OP_MAF:    begin mul_a = 33'(afwd_r); mul_b = $signed({17'd0, dt_r}); end
      OP_RINIT:  begin mul_a = 33'(chosen_r); mul_b = $signed({17'd0, dt_r}); end
      OP_MXS:    begin mul_a = 33'(dist_r); mul_b = 33'(sin_r); end
      OP_MYC:    begin mul_a = 33'(dist_r); mul_b = 33'(cos_r); end
      default:   mul_en = 1'b0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Shared CORDIC micro-rotation; the direction comes from y when vectoring
  // and from z when rotating.
  logic signed [35:0] xs, ys, cx_nxt, cy_nxt;
  logic signed [33:0] cz_nxt, ang;
  logic               neg_dir;

  always_comb begin
    xs  = cx_r >>> cmd.iter;
    ys  = cy_r >>> cmd.iter;
    ang = $signed({4'd0, atan_lut(cmd.iter)});
    if (cmd.op == OP_VITER) neg_dir = (cy_r >= 0);
    else                    neg_dir = (cz_r < 0);
    if (neg_dir) begin
      cx_nxt = cx_r + ys;
      cy_nxt = cy_r - xs;
      cz_nxt = cz_r + ang;
    end else begin
      cx_nxt = cx_r - ys;
      cy_nxt = cy_r + xs;
      cz_nxt = cz_r - ang;
    end
  end

  // Vectoring set-up from the quaternion products.
  logic signed [35:0] siny, cosy;
  logic signed [34:0] imu_sum;
  always_comb begin
    siny    = 36'(sa_r) <<< 1;
    cosy    = 36'sd268435456 - (36'(ca_r) <<< 1);
    imu_sum = 35'(imu_r) + 35'($signed(prod_r[40:8]));
  end

  // Slip decision.
  logic [16:0]        alat_abs;
  logic signed [31:0] enc16;
  logic signed [32:0] gap;
  logic [32:0]        gap_abs;
  logic               lat_now, fwd_now;
  logic [31:0]        hd_round;
  always_comb begin
    alat_abs = alat_r[15] ? 17'(-17'(alat_r)) : 17'(alat_r);
    enc16    = 32'(enc_r) <<< 8;
    gap      = 33'(imu_r) - 33'(enc16);
    gap_abs  = gap[32] ? 33'(-gap) : 33'(gap);
    lat_now  = alat_abs > {2'd0, lat_lim_r};
    fwd_now  = gap_abs > {2'd0, fwd_lim_r};
    hd_round = cz_r[31:0] + 32'h0000_8000;
  end

  // Rotation set-up.
  logic signed [33:0] zh;
  always_comb zh = 34'(hd_r) <<< 16;

  logic signed [34:0] xsum, ysum;
  always_comb begin
    xsum = 35'(xpos_r) - 35'($signed(prod_r[63:30]));
    ysum = 35'(ypos_r) + 35'($signed(prod_r[63:30]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r  <= '0;
      start_y_r  <= '0;
      start_hd_r <= '0;
      lat_lim_r  <= 15'd384;
      fwd_lim_r  <= 31'd13107;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_X:       start_x_r  <= cfg_wdata;
        CFG_START_Y:       start_y_r  <= cfg_wdata;
        CFG_START_HEADING: start_hd_r <= cfg_wdata[15:0];
        CFG_LAT_LIMIT:     lat_lim_r  <= cfg_wdata[14:0];
        CFG_FWD_LIMIT:     fwd_lim_r  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xpos_r   <= '0;
      ypos_r   <= '0;
      hd_r     <= '0;
      imu_r    <= '0;
      chosen_r <= '0;
      lat_r    <= 1'b0;
      fwd_r    <= 1'b0;
      upd_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_OUT) ovalid_r <= 1'b1;
      else if (out_tready)  ovalid_r <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          lat_r <= 1'b0;
          fwd_r <= 1'b0;
          upd_r <= 1'b0;
        end
        OP_DECIDE: begin
          if (mode_r) begin
            xpos_r   <= start_x_r;
            ypos_r   <= start_y_r;
            hd_r     <= start_hd_r;
            imu_r    <= '0;
            chosen_r <= '0;
          end
        end
        OP_VINIT: imu_r <= sat32(imu_sum);
        OP_VDONE: begin
          hd_r     <= degen_r ? 16'sd0 : $signed(hd_round[31:16]);
          lat_r    <= lat_now;
          fwd_r    <= fwd_now;
          chosen_r <= (lat_now || fwd_now) ? imu_r : enc16;
        end
        OP_MYC: xpos_r <= sat32(xsum);
        OP_UPDY_OUT_PREP: begin
          ypos_r <= sat32(ysum);
          upd_r  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= mul_p;
    case (cmd.op)
      OP_LOAD: begin
        mode_r <= in_tuser;
        enc_r  <= in_tdata[15:0];
        qw_r   <= in_tdata[31:16];
        qx_r   <= in_tdata[47:32];
        qy_r   <= in_tdata[63:48];
        qz_r   <= in_tdata[79:64];
        alat_r <= in_tdata[95:80];
        afwd_r <= in_tdata[111:96];
        dt_r   <= in_tdata[127:112];
      end
      OP_MXY: sa_r <= 34'($signed(prod_r[32:0]));
      OP_MYY: sa_r <= sa_r + 34'($signed(prod_r[32:0]));
      OP_MZZ: ca_r <= 34'($signed(prod_r[32:0]));
      OP_MAF: ca_r <= ca_r + 34'($signed(prod_r[32:0]));
      OP_VINIT: begin
        degen_r <= (siny == 0) && (cosy == 0);
        if (cosy < 0) begin
          cx_r <= -cosy;
          cy_r <= -siny;
          cz_r <= 34'sh0_8000_0000;
        end else begin
          cx_r <= cosy;
          cy_r <= siny;
          cz_r <= '0;
        end
      end
      OP_VITER, OP_RITER: begin
        cx_r <= cx_nxt;
        cy_r <= cy_nxt;
        cz_r <= cz_nxt;
      end
      OP_RINIT: begin
        cx_r <= 36'sd652032874;
        cy_r <= '0;
        if (zh > 34'sd1073741824) begin
          cz_r   <= zh - 34'sh0_8000_0000;
          flip_r <= 1'b1;
        end else if (zh < -34'sd1073741824) begin
          cz_r   <= zh + 34'sh0_8000_0000;
          flip_r <= 1'b1;
        end else begin
          cz_r   <= zh;
          flip_r <= 1'b0;
        end
      end
      OP_RDONE: begin
        sin_r  <= flip_r ? 32'(-cy_r) : 32'(cy_r);
        cos_r  <= flip_r ? 32'(-cx_r) : 32'(cx_r);
        dist_r <= $signed(prod_r[47:16]);
      end
      OP_OUT: odata_r <= {5'd0, upd_r, fwd_r, lat_r, chosen_r, hd_r, ypos_r, xpos_r};
      default: ;
    endcase
  end

  assign sts.restart  = mode_r;
  assign sts.skip     = (dt_r == 16'd0);
  assign sts.out_free = !ovalid_r || out_tready;
  assign out_tvalid   = ovalid_r;
  assign out_tdata    = odata_r;

endmodule

// ----- src/slip_aware_dead_reckoning_unit.sv -----
// Channel | Group             | Contents
// input   | in_tvalid/tready  | tuser: mode; tdata: sensor sample
// result  | out_tvalid/tready | tdata: pose, trusted speed, slip flags, updated
// config  | cfg_we/index/wdata| start pose and slip limits, no read-back
// A fuse request runs one shared CORDIC stage for N iterations, first for the
// heading atan2 and then for the sine and cosine, and reuses one multiplier;
// N is the CORDIC iteration count (CORDIC_ITERATIONS, at most ANGLE_TBL_SIZE).
// The input is free again in the same cycle that the result appears.
// A restart or a zero time step skips this work, and the input is likewise
// free again in the same cycle that its result appears.
// Reset is synchronous and active low; it clears the pose and speeds and
// restores the default slip limits.
// A stalled result is held in the output register; the next request is taken
// at once and waits at the end for the register to free.
module slip_aware_dead_reckoning_unit
  import sadr_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // mode
  input  logic                  in_tuser,
  // encoder_speed, quat_w, quat_x, quat_y, quat_z, accel_lateral,
  // accel_forward, step_time
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pos_x, pos_y, heading, trusted_speed, side slip flag, drive slip flag,
  // updated, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata
);

  sadr_cmd_t cmd;
  sadr_sts_t sts;

  sadr_ctrl #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sadr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- src/sadr_checker.sv -----
module sadr_checker
  import sadr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One request is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // Slip flags only come with an applied fuse step.
  a_flags_need_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[114] |-> !out_tdata[112] && !out_tdata[113])
    else $error("slip flag without update");

  // A result appears only at the end of work, never from the idle state.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without work");

endmodule

bind slip_aware_dead_reckoning_unit sadr_checker u_sadr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
